FILE: hdl/hric_face_weight_top_assert.svh
// Assertion helpers for the face weight block; clk and arst_n must be in scope.
`ifndef HRIC_FACE_WEIGHT_TOP_ASSERT_SVH
`define HRIC_FACE_WEIGHT_TOP_ASSERT_SVH

// property checked every clock outside reset
`define HFW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define HFW_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/hfw_pkg.sv
package hfw_pkg;

	// fixed point format
	localparam int FRAC_BITS   = 20;
	localparam int EPSILON_LSB = 1;

	// field widths
	localparam int SIGN_W = 2;
	localparam int VAL_W  = 21;
	localparam int VEC_W  = 63;
	localparam int COMP_W = 21;
	localparam int CO_W   = 23;
	localparam int LIM_W  = 22;

	// internal widths
	localparam int S_W    = FRAC_BITS + 4;          // saturating signed scalar
	localparam int PRD_W  = 2 * COMP_W;
	localparam int SUM_W  = PRD_W + 2;
	localparam int DOT_SH = 32 - FRAC_BITS;
	localparam int NUM_W  = 2 * FRAC_BITS + 1;      // dividend magnitude
	localparam int DEN_W  = FRAC_BITS + 2;          // divisor magnitude
	localparam int QB     = FRAC_BITS + 3;          // quotient bits below saturation
	localparam int Q_W    = QB + 1;                 // saturated quotient magnitude
	localparam int HI_W   = NUM_W - QB;

	// Courant ramp: numerator below 2^RP_W, exact reciprocal multiply
	localparam int RP_W   = 2 * FRAC_BITS - 1;
	localparam int RCP_W  = 2 * FRAC_BITS;
	localparam int RCP_SH = 3 * FRAC_BITS - 2;
	localparam int RS_W   = RP_W + RCP_W;

	// flux sign codes
	localparam logic [SIGN_W-1:0] FLUX_NEG = 2'd0;
	localparam logic [SIGN_W-1:0] FLUX_POS = 2'd2;

	// constants
	localparam longint ONE_L   = longint'(1) << FRAC_BITS;
	localparam longint TH_LO_L = (3 * ONE_L + 5) / 10;
	localparam longint TH_HI_L = (7 * ONE_L + 5) / 10;
	localparam longint SMAX_L  = (longint'(1) << (FRAC_BITS + 3)) - 1;
	localparam longint RAMP_L  = TH_HI_L - TH_LO_L;

	localparam logic [VAL_W-1:0]        ONE_V    = VAL_W'(ONE_L);
	localparam logic signed [S_W-1:0]   ONE_S    = S_W'(ONE_L);
	localparam logic signed [S_W-1:0]   HALF_S   = S_W'(ONE_L / 2);
	localparam logic signed [S_W-1:0]   SMAX_S   = S_W'(SMAX_L);
	localparam logic [Q_W-1:0]          QSAT     = Q_W'(SMAX_L + 1);
	localparam logic [Q_W-1:0]          ONE_Q    = Q_W'(ONE_L);
	localparam logic [Q_W-1:0]          TWO_Q    = Q_W'(2 * ONE_L);
	localparam logic [LIM_W-1:0]        TWO_LIM  = LIM_W'(2 * ONE_L);
	localparam logic [CO_W-1:0]         TH_LO_C  = CO_W'(TH_LO_L);
	localparam logic [CO_W-1:0]         TH_HI_C  = CO_W'(TH_HI_L);
	localparam logic [RCP_W-1:0]        RAMP_RCP =
		RCP_W'(((longint'(1) << RCP_SH) + RAMP_L - 1) / RAMP_L);
	localparam logic signed [VAL_W+1:0] EPS_S    = (VAL_W + 2)'(EPSILON_LSB);

	// side data that travels alongside each face through the dividers
	typedef struct packed {
		logic                    pos;
		logic                    nonneg;
		logic                    upwind;
		logic                    ramp;
		logic                    qneg;
		logic [VAL_W-1:0]        vp;
		logic [VAL_W-1:0]        vn;
		logic [VAL_W-1:0]        th;
		logic [VAL_W-1:0]        cdw;
		logic [VAL_W-1:0]        dh;
		logic [VAL_W-1:0]        fw;
		logic [CO_W-1:0]         co;
		logic signed [S_W-1:0]   c;
	} hfw_side_t;

endpackage

FILE: hdl/hfw_face_if.sv
interface hfw_face_if;
	import hfw_pkg::*;

	logic              valid;
	logic              ready;
	logic [SIGN_W-1:0] flux_sign;
	logic [VAL_W-1:0]  value_owner;
	logic [VAL_W-1:0]  value_neighbour;
	logic [VEC_W-1:0]  grad_owner;
	logic [VEC_W-1:0]  grad_neighbour;
	logic [VEC_W-1:0]  centre_delta;
	logic [CO_W-1:0]   courant;
	logic [VAL_W-1:0]  blend;
	logic [VAL_W-1:0]  cd_weight;

	modport source (output valid, flux_sign, value_owner, value_neighbour, grad_owner,
		grad_neighbour, centre_delta, courant, blend, cd_weight, input ready);
	modport sink (input valid, flux_sign, value_owner, value_neighbour, grad_owner,
		grad_neighbour, centre_delta, courant, blend, cd_weight, output ready);
endinterface

FILE: hdl/hfw_result_if.sv
interface hfw_result_if;
	import hfw_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] face_weight;
	logic [LIM_W-1:0] limiter_value;
	logic             fell_to_upwind;

	modport source (output valid, face_weight, limiter_value, fell_to_upwind, input ready);
	modport sink (input valid, face_weight, limiter_value, fell_to_upwind, output ready);
endinterface

FILE: hdl/hric_face_weight_top.sv
// Face weight and limiter of the high-resolution interface-capturing scheme. One face
// beat is taken every cycle while the output side keeps up; results leave in the order
// their faces were accepted. Most of the pipeline depth lies in three pipelined
// dividers (normalised value, weight, limiter), each 24 stages deep: an overflow check
// and then one quotient bit per stage. The Courant ramp divides by a fixed width and
// takes two stages of reciprocal multiply. The whole pipeline holds when the output
// register and its skid stage are both full; ready is a registered signal.
module hric_face_weight_top (
	input  logic         clk,
	input  logic         arst_n,
	hfw_face_if.sink     face,
	hfw_result_if.source result
);
	import hfw_pkg::*;

	localparam int T_W = SUM_W + 2;
	localparam logic signed [T_W-1:0] ONE_T = T_W'(ONE_L);

	logic adv;

	// S1: unpack and dot-product lanes
	logic                    v_s1;
	hfw_side_t               side_s1;
	logic signed [PRD_W-1:0] p_s1 [3];
	// S2..S5: upwind estimate and divider operands
	logic                    v_s2, v_s3, v_s4, v_s5;
	hfw_side_t               side_s2, side_s3, side_s4, side_s5;
	logic signed [SUM_W-1:0] sum_s2, dot_s3;
	logic [VAL_W-1:0]        upw_s4;
	logic [NUM_W-1:0]        num_s5;
	logic [DEN_W-1:0]        den_s5;
	// S6..S9: blend and ramp operands
	logic                    v_s6, v_s7, v_s8, v_s9;
	hfw_side_t               side_s6, side_s7, side_s8, side_s9;
	logic [VAL_W-1:0]        bds_s6, hric_s8;
	logic [2*VAL_W-1:0]      m1_s7, m2_s7;
	logic [RP_W-1:0]         rm_s9;
	// S9a, S9b: Courant ramp by reciprocal multiply
	logic                    v_s9a, v_s9b;
	hfw_side_t               side_s9a, side_s9b;
	logic [2*FRAC_BITS-1:0]  pp_hh_s9a, pp_hl_s9a, pp_lh_s9a, pp_ll_s9a;
	logic [VAL_W-1:0]        rq_s9b;
	// S10: weight divider operands
	logic                    v_s10;
	hfw_side_t               side_s10;
	logic [NUM_W-1:0]        wnum_s10;
	logic [DEN_W-1:0]        wden_s10;
	// S11..S14: limiter
	logic                    v_s11, v_s12, v_s13, v_s14;
	hfw_side_t               side_s11, side_s12, side_s13, side_s14;
	logic [2*VAL_W-1:0]      pa_s12, pb_s12, pc_s12, pd_s12;
	logic [VAL_W-1:0]        phif_s13, phicd_s13;
	logic [NUM_W-1:0]        num_s14;
	logic [DEN_W-1:0]        den_s14;

	// divider outputs
	logic             dc_v, dw_v, dl_v;
	logic [Q_W-1:0]   dc_q, dw_q, dl_q;
	hfw_side_t        dc_side, dw_side, dl_side;

	// output register and skid stage
	logic             out_v_q, sk_v_q;
	logic [VAL_W-1:0] out_fw_q, sk_fw_q;
	logic [LIM_W-1:0] out_lim_q, sk_lim_q;
	logic             out_up_q, sk_up_q;

	assign adv        = !sk_v_q;
	assign face.ready = adv;

	// ---------------- S1 ----------------
	hfw_side_t        in_side;
	logic [VEC_W-1:0] g_sel;

	always_comb begin
		in_side        = '0;
		in_side.pos    = face.flux_sign == FLUX_POS;
		in_side.nonneg = face.flux_sign != FLUX_NEG;
		in_side.vp     = face.value_owner;
		in_side.vn     = face.value_neighbour;
		in_side.co     = face.courant;
		in_side.th     = (face.blend > ONE_V) ? ONE_V : face.blend;
		in_side.cdw    = (face.cd_weight > ONE_V) ? ONE_V : face.cd_weight;
		g_sel          = in_side.pos ? face.grad_owner : face.grad_neighbour;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= in_side;
			for (int k = 0; k < 3; k++)
				p_s1[k] <= $signed(g_sel[k*COMP_W +: COMP_W])
					* $signed(face.centre_delta[k*COMP_W +: COMP_W]);
		end
	end

	// ---------------- S2: lane sum ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			sum_s2  <= SUM_W'(p_s1[0]) + SUM_W'(p_s1[1]) + SUM_W'(p_s1[2]);
		end
	end

	// ---------------- S3: rescale, truncating toward zero ----------------
	localparam logic signed [SUM_W-1:0] DOT_BIAS = SUM_W'((longint'(1) << DOT_SH) - 1);
	logic signed [SUM_W-1:0] sum_adj;

	assign sum_adj = sum_s2[SUM_W-1] ? sum_s2 + DOT_BIAS : sum_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_s2;
			dot_s3  <= sum_adj >>> DOT_SH;
		end
	end

	// ---------------- S4: far-upwind value clamped to [0,1] ----------------
	logic signed [T_W-1:0] upw_t, d2;

	always_comb begin
		d2 = T_W'(dot_s3) <<< 1;
		if (side_s3.pos) upw_t = T_W'($signed({1'b0, side_s3.vn})) - d2;
		else             upw_t = T_W'($signed({1'b0, side_s3.vp})) + d2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			if (upw_t[T_W-1])      upw_s4 <= '0;
			else if (upw_t > ONE_T) upw_s4 <= ONE_V;
			else                    upw_s4 <= VAL_W'(upw_t);
		end
	end

	// ---------------- S5: operands of the normalised value ----------------
	logic [VAL_W-1:0]        donor, accpt;
	logic signed [VAL_W:0]   dn, den0;
	logic signed [VAL_W+1:0] den_e;
	logic [VAL_W:0]          dn_mag;
	logic [VAL_W+1:0]        den_mag;
	hfw_side_t               side5_n;

	always_comb begin
		donor   = side_s4.pos ? side_s4.vp : side_s4.vn;
		accpt   = side_s4.pos ? side_s4.vn : side_s4.vp;
		dn      = $signed({1'b0, donor}) - $signed({1'b0, upw_s4});
		den0    = $signed({1'b0, accpt}) - $signed({1'b0, upw_s4});
		// strictly positive gets +eps, zero or negative gets -eps
		if (!den0[VAL_W] && den0 != '0) den_e = (VAL_W + 2)'(den0) + EPS_S;
		else                            den_e = (VAL_W + 2)'(den0) - EPS_S;
		dn_mag  = dn[VAL_W] ? (VAL_W + 1)'(-dn) : (VAL_W + 1)'(dn);
		den_mag = den_e[VAL_W+1] ? (VAL_W + 2)'(-den_e) : (VAL_W + 2)'(den_e);
		side5_n = side_s4;
		side5_n.qneg = dn[VAL_W] ^ den_e[VAL_W+1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side5_n;
			num_s5  <= NUM_W'(dn_mag) << FRAC_BITS;
			den_s5  <= DEN_W'(den_mag);
		end
	end

	hfw_div u_div_c (
		.clk, .arst_n, .en(adv), .in_valid(v_s5), .num(num_s5), .den(den_s5),
		.side_in(side_s5), .out_valid(dc_v), .q(dc_q), .side_out(dc_side)
	);

	// ---------------- S6: normalised value and branch decision ----------------
	logic signed [S_W-1:0] c_n;
	logic                  c_pos;
	hfw_side_t             side6_n;

	always_comb begin
		if (dc_side.qneg)   c_n = -$signed(dc_q);
		else if (dc_q == QSAT) c_n = SMAX_S;
		else                c_n = $signed(dc_q);
		c_pos   = !c_n[S_W-1] && (c_n != '0);
		side6_n = dc_side;
		side6_n.c      = c_n;
		side6_n.upwind = !(c_pos && (c_n < ONE_S) && (dc_side.co < TH_HI_C));
		side6_n.ramp   = dc_side.co > TH_LO_C;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= side6_n;
			bds_s6  <= (c_n <= HALF_S) ? VAL_W'(c_n) << 1 : ONE_V;
		end
	end

	// ---------------- S7: blend products ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_s6;
			m1_s7   <= bds_s6 * side_s6.th;
			m2_s7   <= VAL_W'(side_s6.c) * (ONE_V - side_s6.th);
		end
	end

	// ---------------- S8: blended value ----------------
	logic [2*VAL_W:0] msum;

	assign msum = {1'b0, m1_s7} + {1'b0, m2_s7};

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8 <= side_s7;
			hric_s8 <= VAL_W'(msum >> FRAC_BITS);
		end
	end

	// ---------------- S9: Courant ramp numerator ----------------
	// on the blended path dh is below one and the ramp distance below the ramp width
	logic [VAL_W-1:0] dh;
	logic [CO_W-1:0]  tr;
	hfw_side_t        side9_n;

	always_comb begin
		dh         = hric_s8 - VAL_W'(side_s8.c);
		tr         = TH_HI_C - side_s8.co;
		side9_n    = side_s8;
		side9_n.dh = dh;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9 <= side9_n;
			rm_s9   <= dh[FRAC_BITS-1:0] * tr[FRAC_BITS-2:0];
		end
	end

	// ---------------- S9a: reciprocal partial products ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9a  <= side_s9;
			pp_hh_s9a <= rm_s9[RP_W-1:FRAC_BITS] * RAMP_RCP[RCP_W-1:FRAC_BITS];
			pp_hl_s9a <= rm_s9[RP_W-1:FRAC_BITS] * RAMP_RCP[FRAC_BITS-1:0];
			pp_lh_s9a <= rm_s9[FRAC_BITS-1:0] * RAMP_RCP[RCP_W-1:FRAC_BITS];
			pp_ll_s9a <= rm_s9[FRAC_BITS-1:0] * RAMP_RCP[FRAC_BITS-1:0];
		end
	end

	// ---------------- S9b: ramp quotient, exact over the numerator range ----------------
	logic [RS_W-1:0] rsum;

	assign rsum = (RS_W'(pp_hh_s9a) << (2 * FRAC_BITS)) + (RS_W'(pp_hl_s9a) << FRAC_BITS)
		+ (RS_W'(pp_lh_s9a) << FRAC_BITS) + RS_W'(pp_ll_s9a);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9b <= side_s9a;
			rq_s9b   <= VAL_W'(rsum >> RCP_SH);
		end
	end

	// ---------------- S10: weight operands ----------------
	logic [VAL_W-1:0] dh2;

	assign dh2 = side_s9b.ramp ? rq_s9b : side_s9b.dh;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s10 <= side_s9b;
			wnum_s10 <= NUM_W'(dh2) << FRAC_BITS;
			wden_s10 <= DEN_W'(ONE_S - side_s9b.c);
		end
	end

	hfw_div u_div_w (
		.clk, .arst_n, .en(adv), .in_valid(v_s10), .num(wnum_s10), .den(wden_s10),
		.side_in(side_s10), .out_valid(dw_v), .q(dw_q), .side_out(dw_side)
	);

	// ---------------- S11: owner-side face weight ----------------
	logic [Q_W-1:0] w;
	hfw_side_t      side11_n;

	always_comb begin
		w        = dw_side.upwind ? '0 : dw_q;
		side11_n = dw_side;
		if (dw_side.pos) side11_n.fw = (w > ONE_Q) ? '0 : VAL_W'(ONE_Q - w);
		else             side11_n.fw = (w > ONE_Q) ? ONE_V : VAL_W'(w);
	end

	always_ff @(posedge clk) begin
		if (adv) side_s11 <= side11_n;
	end

	// ---------------- S12: interpolation products ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s12 <= side_s11;
			pa_s12   <= side_s11.fw * side_s11.vp;
			pb_s12   <= (ONE_V - side_s11.fw) * side_s11.vn;
			pc_s12   <= side_s11.cdw * side_s11.vp;
			pd_s12   <= (ONE_V - side_s11.cdw) * side_s11.vn;
		end
	end

	// ---------------- S13: face values ----------------
	logic [2*VAL_W:0] fsum, csum;

	assign fsum = {1'b0, pa_s12} + {1'b0, pb_s12};
	assign csum = {1'b0, pc_s12} + {1'b0, pd_s12};

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s13  <= side_s12;
			phif_s13  <= VAL_W'(fsum >> FRAC_BITS);
			phicd_s13 <= VAL_W'(csum >> FRAC_BITS);
		end
	end

	// ---------------- S14: limiter operands ----------------
	logic [VAL_W-1:0]        phiu;
	logic signed [VAL_W:0]   ln, ld0;
	logic signed [VAL_W+1:0] ld;
	logic [VAL_W:0]          ln_mag;
	logic [VAL_W+1:0]        ld_mag;
	hfw_side_t               side14_n;

	always_comb begin
		phiu   = side_s13.nonneg ? side_s13.vp : side_s13.vn;
		ln     = $signed({1'b0, phif_s13}) - $signed({1'b0, phiu});
		ld0    = $signed({1'b0, phicd_s13}) - $signed({1'b0, phiu});
		// zero or positive gets +eps here
		if (ld0[VAL_W]) ld = (VAL_W + 2)'(ld0) - EPS_S;
		else            ld = (VAL_W + 2)'(ld0) + EPS_S;
		ln_mag = ln[VAL_W] ? (VAL_W + 1)'(-ln) : (VAL_W + 1)'(ln);
		ld_mag = ld[VAL_W+1] ? (VAL_W + 2)'(-ld) : (VAL_W + 2)'(ld);
		side14_n      = side_s13;
		side14_n.qneg = ln[VAL_W] ^ ld[VAL_W+1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s14 <= side14_n;
			num_s14  <= NUM_W'(ln_mag) << FRAC_BITS;
			den_s14  <= DEN_W'(ld_mag);
		end
	end

	hfw_div u_div_l (
		.clk, .arst_n, .en(adv), .in_valid(v_s14), .num(num_s14), .den(den_s14),
		.side_in(side_s14), .out_valid(dl_v), .q(dl_q), .side_out(dl_side)
	);

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5}      <= '0;
			{v_s6, v_s7, v_s8, v_s9, v_s10}     <= '0;
			{v_s9a, v_s9b}                      <= '0;
			{v_s11, v_s12, v_s13, v_s14}        <= '0;
		end else if (adv) begin
			v_s1  <= face.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= dc_v;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s9a <= v_s9;
			v_s9b <= v_s9a;
			v_s10 <= v_s9b;
			v_s11 <= dw_v;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// ---------------- result: limiter clamp, output register and skid ----------------
	logic             fire;
	logic [LIM_W-1:0] lim_n;

	assign fire  = dl_v && adv;
	assign lim_n = dl_side.qneg ? '0 : ((dl_q > TWO_Q) ? TWO_LIM : LIM_W'(dl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= fire;
			end
		end else if (fire) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			if (sk_v_q) begin
				out_fw_q  <= sk_fw_q;
				out_lim_q <= sk_lim_q;
				out_up_q  <= sk_up_q;
			end else begin
				out_fw_q  <= dl_side.fw;
				out_lim_q <= lim_n;
				out_up_q  <= dl_side.upwind;
			end
		end else if (fire) begin
			sk_fw_q  <= dl_side.fw;
			sk_lim_q <= lim_n;
			sk_up_q  <= dl_side.upwind;
		end
	end

	assign result.valid          = out_v_q;
	assign result.face_weight    = out_fw_q;
	assign result.limiter_value  = out_lim_q;
	assign result.fell_to_upwind = out_up_q;

	// checks
`include "hric_face_weight_top_assert.svh"
	`HFW_IMPLY(a_skid_behind_out, sk_v_q, out_v_q, "skid holds a beat while output is empty")
	`HFW_IMPLY(a_fw_range, out_v_q, out_fw_q <= ONE_V, "face weight above one")
	`HFW_IMPLY(a_lim_range, out_v_q, out_lim_q <= TWO_LIM, "limiter above two")
	`HFW_IMPLY(a_upwind_end, out_v_q && out_up_q, out_fw_q == '0 || out_fw_q == ONE_V, "bad upwind")
endmodule

FILE: hdl/hfw_div.sv
// Pipelined unsigned divider, one quotient bit per stage, quotient saturated.
module hfw_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [hfw_pkg::NUM_W-1:0] num,
	input  logic [hfw_pkg::DEN_W-1:0] den,
	input  hfw_pkg::hfw_side_t        side_in,
	output logic                      out_valid,
	output logic [hfw_pkg::Q_W-1:0]   q,
	output hfw_pkg::hfw_side_t        side_out
);
	import hfw_pkg::*;

	logic             v_s    [0:QB];
	logic [DEN_W-1:0] rem_s  [0:QB];
	logic [DEN_W-1:0] den_s  [0:QB];
	logic [QB-1:0]    lo_s   [0:QB];
	logic [QB-1:0]    q_s    [0:QB];
	logic             ovf_s  [0:QB];
	hfw_side_t        side_s [0:QB];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i <= QB; i++) v_s[i] <= v_s[i-1];
		end
	end

	// entry: quotient overflow check, remainder seeded with the high dividend bits
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= DEN_W'(num[NUM_W-1:QB]) >= den;
			rem_s[0]  <= DEN_W'(num[NUM_W-1:QB]);
			lo_s[0]   <= num[QB-1:0];
			den_s[0]  <= den;
			q_s[0]    <= '0;
			side_s[0] <= side_in;
		end
	end

	// restoring steps
	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DEN_W:0] t;
		logic           ge;

		assign t  = {rem_s[k-1], lo_s[k-1][QB-k]};
		assign ge = t >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DEN_W'(t - {1'b0, den_s[k-1]}) : DEN_W'(t);
				q_s[k]    <= {q_s[k-1][QB-2:0], ge};
				lo_s[k]   <= lo_s[k-1];
				den_s[k]  <= den_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign q         = ovf_s[QB] ? QSAT : {1'b0, q_s[QB]};
	assign side_out  = side_s[QB];
endmodule

FILE: dv/tb_hric_face_weight_top.sv
module tb_hric_face_weight_top;
	import hfw_pkg::*;

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam longint SMAX = (longint'(1) << (FRAC_BITS + 3)) - 1;
	localparam longint SMIN = -(longint'(1) << (FRAC_BITS + 3));
	localparam longint TH_LO = (3 * ONE + 5) / 10;
	localparam longint TH_HI = (7 * ONE + 5) / 10;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [SIGN_W-1:0] flux_sign;
		logic [VAL_W-1:0]  value_owner;
		logic [VAL_W-1:0]  value_neighbour;
		logic [VEC_W-1:0]  grad_owner;
		logic [VEC_W-1:0]  grad_neighbour;
		logic [VEC_W-1:0]  centre_delta;
		logic [CO_W-1:0]   courant;
		logic [VAL_W-1:0]  blend;
		logic [VAL_W-1:0]  cd_weight;
	} face_t;

	typedef struct {
		logic [VAL_W-1:0] face_weight;
		logic [LIM_W-1:0] limiter_value;
		logic             fell_to_upwind;
	} weight_t;

	// fixed point helpers
	function automatic longint sat_s(longint x);
		if (x > SMAX) return SMAX;
		if (x < SMIN) return SMIN;
		return x;
	endfunction

	function automatic longint clamp_s(longint x, longint lo, longint hi);
		if (x < lo) return lo;
		if (x > hi) return hi;
		return x;
	endfunction

	// signed dot product of packed Q4.16 vectors, rescaled to ONE
	function automatic longint dot_vec(logic [VEC_W-1:0] a, logic [VEC_W-1:0] b);
		longint s;
		logic signed [COMP_W-1:0] ca, cb;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			ca = a[k*COMP_W +: COMP_W];
			cb = b[k*COMP_W +: COMP_W];
			s += longint'(ca) * longint'(cb);
		end
		return sat_s(s / (longint'(1) << (32 - FRAC_BITS)));
	endfunction

	// expected weight, limiter and fallback flag of one face
	function automatic weight_t predict_weight(face_t f);
		weight_t r;
		logic pos, nonneg, upwind;
		longint vp, vn, co, th, cdw, donor, accept, upw, den, c, bds, hric, w, fw;
		longint phif, phiu, phicd, lden, lim;
		pos = (f.flux_sign == FLUX_POS);
		nonneg = (f.flux_sign != FLUX_NEG);
		vp = f.value_owner;
		vn = f.value_neighbour;
		co = f.courant;
		th = clamp_s(f.blend, 0, ONE);
		cdw = clamp_s(f.cd_weight, 0, ONE);
		upwind = 0;
		if (pos) begin
			donor = vp;
			accept = vn;
			upw = sat_s(vn - sat_s(2 * dot_vec(f.grad_owner, f.centre_delta)));
		end else begin
			donor = vn;
			accept = vp;
			upw = sat_s(vp + sat_s(2 * dot_vec(f.grad_neighbour, f.centre_delta)));
		end
		upw = clamp_s(upw, 0, ONE);
		den = accept - upw;
		den = den > 0 ? den + EPSILON_LSB : den - EPSILON_LSB;
		c = sat_s(((donor - upw) * ONE) / den);
		// bounded-downwind
		if (c > 0 && c <= ONE / 2) bds = 2 * c;
		else if (c > ONE / 2 && c <= ONE) bds = ONE;
		else bds = c;
		if (c > 0 && c < ONE && co < TH_HI) begin
			hric = (bds * th + c * (ONE - th)) / ONE;
			if (co > TH_LO)
				hric = c + ((hric - c) * (TH_HI - co)) / (TH_HI - TH_LO);
			w = ((hric - c) * ONE) / (ONE - c);
		end else begin
			w = 0;
			upwind = 1;
		end
		fw = clamp_s(pos ? ONE - w : w, 0, ONE);
		// equivalent limiter against central differencing
		phif = (fw * vp + (ONE - fw) * vn) / ONE;
		phiu = nonneg ? vp : vn;
		phicd = (cdw * vp + (ONE - cdw) * vn) / ONE;
		lden = phicd - phiu;
		lden = lden >= 0 ? lden + EPSILON_LSB : lden - EPSILON_LSB;
		lim = clamp_s(((phif - phiu) * ONE) / lden, 0, 2 * ONE);
		r.face_weight = fw[VAL_W-1:0];
		r.limiter_value = lim[LIM_W-1:0];
		r.fell_to_upwind = upwind;
		return r;
	endfunction

	// in-order store of expected results
	class weight_board;
		weight_t pending_q[$];
		int mismatches = 0;
		int checked = 0;
		int upwind_seen = 0;

		function void note_face(face_t f);
			pending_q.push_back(predict_weight(f));
		endfunction

		function void check_result(weight_t got);
			weight_t exp_r;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with nothing pending fw=%0d lim=%0d up=%0b",
						got.face_weight, got.limiter_value, got.fell_to_upwind);
				return;
			end
			exp_r = pending_q.pop_front();
			checked++;
			if (got.fell_to_upwind) upwind_seen++;
			if (got.face_weight !== exp_r.face_weight
					|| got.limiter_value !== exp_r.limiter_value
					|| got.fell_to_upwind !== exp_r.fell_to_upwind) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d fw exp %0d got %0d, lim exp %0d got %0d, up exp %0b got %0b",
						checked, exp_r.face_weight, got.face_weight, exp_r.limiter_value,
						got.limiter_value, exp_r.fell_to_upwind, got.fell_to_upwind);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	hfw_face_if face ();
	hfw_result_if result ();

	hric_face_weight_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.face(face.sink),
		.result(result.sink)
	);

	weight_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	int faces_sent = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = HOLD_CYCLES;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		face_t f;
		weight_t r;
		if (arst_n && face.valid && face.ready) begin
			f.flux_sign = face.flux_sign;
			f.value_owner = face.value_owner;
			f.value_neighbour = face.value_neighbour;
			f.grad_owner = face.grad_owner;
			f.grad_neighbour = face.grad_neighbour;
			f.centre_delta = face.centre_delta;
			f.courant = face.courant;
			f.blend = face.blend;
			f.cd_weight = face.cd_weight;
			board.note_face(f);
		end
		if (arst_n && result.valid && result.ready) begin
			r.face_weight = result.face_weight;
			r.limiter_value = result.limiter_value;
			r.fell_to_upwind = result.fell_to_upwind;
			board.check_result(r);
		end
	end

	// one beat on the face channel, with an optional idle gap first
	task automatic send_face(face_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			face.valid <= 1'b0;
		end
		@(negedge clk);
		face.valid <= 1'b1;
		face.flux_sign <= f.flux_sign;
		face.value_owner <= f.value_owner;
		face.value_neighbour <= f.value_neighbour;
		face.grad_owner <= f.grad_owner;
		face.grad_neighbour <= f.grad_neighbour;
		face.centre_delta <= f.centre_delta;
		face.courant <= f.courant;
		face.blend <= f.blend;
		face.cd_weight <= f.cd_weight;
		do @(posedge clk); while (!face.ready);
		faces_sent++;
	endtask

	task automatic wait_drained();
		while (board.pending_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [VEC_W-1:0] rand_vec(bit wide);
		logic [VEC_W-1:0] v;
		logic signed [COMP_W-1:0] cmp;
		v = VEC_W'({$urandom, $urandom});
		if (!wide)
			for (int k = 0; k < 3; k++) begin
				cmp = COMP_W'($signed($urandom_range(16383)) - 8192);
				v[k*COMP_W +: COMP_W] = cmp;
			end
		return v;
	endfunction

	function automatic logic [VAL_W-1:0] rand_frac(bit wide);
		int pick;
		pick = $urandom_range(9);
		if (wide) return VAL_W'($urandom);
		if (pick == 0) return '0;
		if (pick == 1) return ONE_V;
		return VAL_W'($urandom_range(ONE));
	endfunction

	// mostly well-formed faces, some raw noise across the full field widths
	function automatic face_t rand_face();
		face_t f;
		bit wide;
		wide = ($urandom_range(9) < 2);
		f.flux_sign = SIGN_W'($urandom);
		f.value_owner = rand_frac(wide);
		f.value_neighbour = rand_frac(wide);
		f.grad_owner = rand_vec(wide);
		f.grad_neighbour = rand_vec(wide);
		f.centre_delta = rand_vec(wide);
		case ($urandom_range(3))
			0: f.courant = CO_W'($urandom);
			1: f.courant = CO_W'($urandom_range(TH_LO));
			default: f.courant = CO_W'($urandom_range(TH_HI + 2000, TH_LO - 2000));
		endcase
		f.blend = rand_frac(wide);
		f.cd_weight = rand_frac(wide);
		return f;
	endfunction

	function automatic face_t mk_face(logic [SIGN_W-1:0] s, longint vo, longint vnb,
			logic [VEC_W-1:0] go, logic [VEC_W-1:0] gn, logic [VEC_W-1:0] dc,
			longint co, longint bl, longint cw);
		face_t f;
		f.flux_sign = s;
		f.value_owner = VAL_W'(vo);
		f.value_neighbour = VAL_W'(vnb);
		f.grad_owner = go;
		f.grad_neighbour = gn;
		f.centre_delta = dc;
		f.courant = CO_W'(co);
		f.blend = VAL_W'(bl);
		f.cd_weight = VAL_W'(cw);
		return f;
	endfunction

	initial begin
		face_t dir_q[$];
		logic [VEC_W-1:0] vmax, vmin, vsmall, vneg;
		face.valid = 1'b0;
		face.flux_sign = '0;
		face.value_owner = '0;
		face.value_neighbour = '0;
		face.grad_owner = '0;
		face.grad_neighbour = '0;
		face.centre_delta = '0;
		face.courant = '0;
		face.blend = '0;
		face.cd_weight = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		vmax = {3{21'h0FFFFF}};
		vmin = {3{21'h100000}};
		vsmall = {3{21'h001000}};
		vneg = {3{21'h1FF000}};
		// directed: flux codes, extremes, thresholds, zero denominators, over-range blends
		dir_q.push_back(mk_face(FLUX_NEG, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(mk_face(FLUX_POS, ONE, 0, vsmall, vsmall, vsmall, 0, ONE, ONE));
		dir_q.push_back(mk_face(2'd1, ONE / 4, ONE / 2, vsmall, vneg, vsmall, 100, ONE, ONE / 2));
		dir_q.push_back(mk_face(2'd3, ONE / 4, ONE / 2, vsmall, vneg, vsmall, 100, ONE, ONE / 2));
		dir_q.push_back(mk_face(FLUX_POS, ONE / 3, ONE, vneg, vsmall, vsmall, TH_LO, ONE / 2,
			ONE / 2));
		dir_q.push_back(mk_face(FLUX_POS, ONE / 3, ONE, vneg, vsmall, vsmall, TH_LO + 1, ONE,
			ONE / 2));
		dir_q.push_back(mk_face(FLUX_POS, ONE / 3, ONE, vneg, vsmall, vsmall, TH_HI - 1, ONE,
			ONE / 2));
		dir_q.push_back(mk_face(FLUX_POS, ONE / 3, ONE, vneg, vsmall, vsmall, TH_HI, ONE, 0));
		dir_q.push_back(mk_face(FLUX_NEG, ONE, ONE / 5, vsmall, vneg, vsmall, 0, 0, ONE));
		dir_q.push_back(mk_face(FLUX_NEG, 2097151, 2097151, vmax, vmax, vmax, 8388607,
			2097151, 2097151));
		dir_q.push_back(mk_face(FLUX_POS, 2097151, 0, vmin, vmin, vmin, 8388607, 2097151,
			2097151));
		dir_q.push_back(mk_face(FLUX_POS, 0, 2097151, vmax, vmin, vmax, 0, 2097151, 0));
		dir_q.push_back(mk_face(FLUX_NEG, ONE / 2, ONE / 2, 0, 0, 0, 0, ONE, ONE));
		dir_q.push_back(mk_face(FLUX_POS, ONE / 2, ONE / 2, 0, 0, 0, 0, ONE, ONE / 2));
		dir_q.push_back(mk_face(2'd1, ONE, ONE, vmax, vmin, vmax, TH_LO, ONE, ONE));
		dir_q.push_back(mk_face(FLUX_POS, ONE / 10, ONE, 0, 0, 0, 0, ONE, ONE / 2));
		dir_q.push_back(mk_face(FLUX_POS, ONE * 3 / 4, ONE, 0, 0, 0, 0, ONE, ONE / 2));
		dir_q.push_back(mk_face(FLUX_NEG, ONE, ONE / 10, 0, 0, 0, TH_LO + 5000, ONE / 2,
			ONE));
		foreach (dir_q[i]) send_face(dir_q[i]);

		// random phases: steady, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 67 : 31) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 67 : 31) : 0;
			if (ph == 0) hold_req = 1;
			for (int n = 0; n < 110; n++)
				send_face(rand_face());
			// after the sender-idle phase, the sender pauses until the pipeline has drained
			if (ph == 1) begin
				@(negedge clk);
				face.valid <= 1'b0;
				wait_drained();
			end
		end
		@(negedge clk);
		face.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d faces; %0d results checked, %0d of them upwind fallback.",
			faces_sent, board.checked, board.upwind_seen);
		$display("Covered flux codes, value and vector extremes, Courant thresholds and stalls.");
		if (board.mismatches == 0 && board.pending_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", board.mismatches,
				board.pending_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
